>>> rtl/vpt_pkg.sv
// Shared types, constants and helper functions for the vertex transform pipeline.
package vpt_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam logic [7:0] ALPHA_KEEP = 8'd255;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

  typedef logic [NUM_REGS-1:0][63:0] mat_regs_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic       last;
  } side_t;

  typedef struct packed {
    logic signed [31:0] xp;
    logic signed [31:0] yp;
    logic signed [31:0] zp;
    side_t              side;
  } carry_t;

  // Clamp a wide signed value into a 32-bit word.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > 66'(WORD_MAX)) begin
      res = WORD_MAX;
    end else if (v < 66'(WORD_MIN)) begin
      res = WORD_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Matrix entry M[r][c]: even columns in the low half of a register, odd in the high half.
  function automatic logic signed [31:0] mat_entry(input mat_regs_t m, input logic [1:0] r,
                                                   input logic [1:0] c);
    logic [REG_IDX_W-1:0] idx;
    logic [63:0]          reg_val;
    idx = {r, c[1]};
    reg_val = m[idx];
    return c[0] ? reg_val[63:32] : reg_val[31:0];
  endfunction

endpackage

>>> rtl/vpt_dot.sv
// Three-stage matrix multiply: products, column sums, then shift, translate and clamp.
module vpt_dot #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [7:0]         in_vertex_alpha,
  input  logic [7:0]         in_group_alpha,
  input  logic               in_batch_last,
  input  vpt_pkg::mat_regs_t mreg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_w,
  output vpt_pkg::carry_t    out_carry
);
  import vpt_pkg::*;

  logic [2:0]         v_r;
  logic [3:0]         en;
  logic signed [31:0] pos [3];
  logic signed [63:0] prod_r [3][4];
  logic signed [65:0] sum_r [4];
  logic signed [31:0] col_r [4];
  side_t              side_r [3];

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  // A stage may load when it is empty or when the stage after it moves.
  assign en[3] = out_ready;
  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_en
      assign en[k] = !v_r[k] || en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r][c] <= mat_entry(mreg, 2'(r), 2'(c)) * pos[r];
        end
      end
      side_r[0].alpha <= (in_group_alpha < ALPHA_KEEP) ? in_group_alpha : in_vertex_alpha;
      side_r[0].last  <= in_batch_last;
    end
    if (en[1]) begin
      for (int c = 0; c < 4; c++) begin
        sum_r[c] <= 66'(prod_r[0][c]) + 66'(prod_r[1][c]) + 66'(prod_r[2][c]);
      end
      side_r[1] <= side_r[0];
    end
    if (en[2]) begin
      for (int c = 0; c < 4; c++) begin
        col_r[c] <= sat32((sum_r[c] >>> FRAC_BITS) + 66'(mat_entry(mreg, 2'd3, 2'(c))));
      end
      side_r[2] <= side_r[1];
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = v_r[2];
  assign out_w          = col_r[3];
  assign out_carry.xp   = col_r[0];
  assign out_carry.yp   = col_r[1];
  assign out_carry.zp   = col_r[2];
  assign out_carry.side = side_r[2];

endmodule

>>> rtl/vpt_recip.sv
// Pipelined restoring divider forming the clamped reciprocal of w, one quotient bit per stage.
module vpt_recip #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_w,
  input  vpt_pkg::carry_t    in_carry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rhw,
  output logic               out_wz,
  output vpt_pkg::carry_t    out_carry
);
  import vpt_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;

  logic [QW+1:0]   v_r;
  logic [QW+2:0]   en;
  logic [31:0]     d_r    [0:QW];
  logic [31:0]     rem_r  [0:QW];
  logic [QW-1:0]   q_r    [0:QW];
  logic            neg_r  [0:QW];
  logic            zero_r [0:QW];
  carry_t          car_r  [0:QW];
  logic signed [31:0] rhw_r;
  logic            wz_r;
  carry_t          carf_r;
  logic [31:0]     mag;
  logic [63:0]     qx;

  assign en[QW+2] = out_ready;
  genvar k;
  generate
    for (k = 0; k < QW + 2; k++) begin : g_en
      assign en[k] = !v_r[k] || en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int s = 1; s < QW + 2; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  assign mag = in_w[31] ? (~in_w + 32'd1) : in_w;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r[0]    <= mag;
      rem_r[0]  <= '0;
      q_r[0]    <= '0;
      neg_r[0]  <= in_w[31];
      zero_r[0] <= (in_w == 32'sd0);
      car_r[0]  <= in_carry;
    end
  end

  // The dividend is a single one at the top quotient position, fed in at the first step.
  generate
    for (k = 1; k <= QW; k++) begin : g_step
      logic [32:0] t;
      logic        ge;
      always_comb begin
        t  = {rem_r[k-1], 1'(k == 1)};
        ge = (t >= {1'b0, d_r[k-1]});
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k]  <= ge ? 32'(t - {1'b0, d_r[k-1]}) : t[31:0];
          q_r[k]    <= {q_r[k-1][QW-2:0], ge};
          d_r[k]    <= d_r[k-1];
          neg_r[k]  <= neg_r[k-1];
          zero_r[k] <= zero_r[k-1];
          car_r[k]  <= car_r[k-1];
        end
      end
    end
  endgenerate

  assign qx = 64'(q_r[QW]);

  always_ff @(posedge clk) begin
    if (en[QW+1]) begin
      if (zero_r[QW]) begin
        rhw_r <= WORD_MAX;
      end else if (neg_r[QW]) begin
        rhw_r <= (qx > 64'h8000_0000) ? WORD_MIN : 32'(-qx);
      end else begin
        rhw_r <= (qx > 64'h7fff_ffff) ? WORD_MAX : qx[31:0];
      end
      wz_r   <= zero_r[QW];
      carf_r <= car_r[QW];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[QW+1];
  assign out_rhw   = rhw_r;
  assign out_wz    = wz_r;
  assign out_carry = carf_r;

endmodule

>>> rtl/vpt_scale.sv
// Two-stage perspective scale: coordinate times rhw, then shift and clamp into the output register.
module vpt_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_rhw,
  input  logic               in_wz,
  input  vpt_pkg::carry_t    in_carry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic signed [31:0] out_screen_z,
  output logic signed [31:0] out_recip_w,
  output logic [7:0]         out_alpha,
  output logic               out_w_zero,
  output logic               out_last
);
  import vpt_pkg::*;

  logic [1:0]         v_r;
  logic [2:0]         en;
  logic signed [63:0] prd_r [3];
  logic signed [31:0] scr_r [3];
  logic signed [31:0] rhw_r [2];
  logic               wz_r  [2];
  side_t              side_r [2];

  assign en[2] = out_ready;
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prd_r[0]  <= in_carry.xp * in_rhw;
      prd_r[1]  <= in_carry.yp * in_rhw;
      prd_r[2]  <= in_carry.zp * in_rhw;
      rhw_r[0]  <= in_rhw;
      wz_r[0]   <= in_wz;
      side_r[0] <= in_carry.side;
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        scr_r[i] <= sat32(66'(prd_r[i]) >>> FRAC_BITS);
      end
      rhw_r[1]  <= rhw_r[0];
      wz_r[1]   <= wz_r[0];
      side_r[1] <= side_r[0];
    end
  end

  assign in_ready     = en[0];
  assign out_valid    = v_r[1];
  assign out_screen_x = scr_r[0];
  assign out_screen_y = scr_r[1];
  assign out_screen_z = scr_r[2];
  assign out_recip_w  = rhw_r[1];
  assign out_alpha    = side_r[1].alpha;
  assign out_w_zero   = wz_r[1];
  assign out_last     = side_r[1].last;

endmodule

>>> rtl/vertex_projective_transform.sv
// Top level of the perspective vertex transform: matrix registers and the three pipeline sections.
// One vertex word is accepted per clock and one result word leaves per clock in steady state,
// as long as out_ready stays high. A vertex passes through the matrix multiply, then the reciprocal
// divider, which produces one quotient bit per stage, and then the final scale into the output
// register. Each stage holds its word when the next one is full, so a stalled output backs up
// stage by stage and empty slots are squeezed out.
// The matrix is written through the register port at byte address 8*i and is read back there.
module vertex_projective_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [7:0]         in_vertex_alpha,
  input  logic [7:0]         in_group_alpha,
  input  logic               in_batch_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic signed [31:0] out_screen_z,
  output logic signed [31:0] out_recip_w,
  output logic [7:0]         out_alpha,
  output logic               out_w_zero,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import vpt_pkg::*;

  localparam logic [63:0] ONE_LO = 64'd1 << FRAC_BITS;
  localparam logic [63:0] ONE_HI = ONE_LO << 32;

  mat_regs_t          mreg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               d_valid, d_ready, r_valid, r_ready;
  logic signed [31:0] d_w, r_rhw;
  logic               r_wz;
  carry_t             d_carry, r_carry;

  // Byte address 8*i selects register i; the low address bits are not decoded.
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mreg_r[0] <= ONE_LO;
      mreg_r[1] <= '0;
      mreg_r[2] <= ONE_HI;
      mreg_r[3] <= '0;
      mreg_r[4] <= '0;
      mreg_r[5] <= ONE_LO;
      mreg_r[6] <= '0;
      mreg_r[7] <= ONE_HI;
    end else if (psel && penable && pwrite) begin
      mreg_r[reg_idx] <= pwdata;
    end
  end

  assign prdata = mreg_r[reg_idx];
  assign pready = 1'b1;

  vpt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_vertex_alpha(in_vertex_alpha),
    .in_group_alpha (in_group_alpha),
    .in_batch_last  (in_batch_last),
    .mreg           (mreg_r),
    .out_valid      (d_valid),
    .out_ready      (d_ready),
    .out_w          (d_w),
    .out_carry      (d_carry)
  );

  vpt_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_w     (d_w),
    .in_carry (d_carry),
    .out_valid(r_valid),
    .out_ready(r_ready),
    .out_rhw  (r_rhw),
    .out_wz   (r_wz),
    .out_carry(r_carry)
  );

  vpt_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (r_valid),
    .in_ready    (r_ready),
    .in_rhw      (r_rhw),
    .in_wz       (r_wz),
    .in_carry    (r_carry),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_screen_x(out_screen_x),
    .out_screen_y(out_screen_y),
    .out_screen_z(out_screen_z),
    .out_recip_w (out_recip_w),
    .out_alpha   (out_alpha),
    .out_w_zero  (out_w_zero),
    .out_last    (out_last)
  );

endmodule

>>> rtl/vpt_checker.sv
// Port-level assertions for the vertex transform, bound to the top level.
module vpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_recip_w,
  input logic        out_w_zero,
  input logic        pready
);

  // A zero w always comes out with the clamped positive reciprocal.
  a_wz_rhw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> out_recip_w == 32'h7fffffff)
    else $error("w_zero without clamped recip_w");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  // The pipeline comes out of reset empty.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A result word that is not taken stays valid and keeps its recip_w value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_recip_w))
    else $error("stalled result word changed");

endmodule

bind vertex_projective_transform vpt_checker u_vpt_checker (.*);

>>> sim/tb_vertex_projective_transform.sv
// Testbench for the perspective vertex transform: directed and random vertices against a predictor.
`timescale 1ns / 100ps

module tb_vertex_projective_transform;
  import vpt_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 2 * FRAC + 8;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] rhw;
    logic [7:0]         alpha;
    logic               wz;
    logic               last;
  } screen_vtx_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [7:0] in_vertex_alpha = '0, in_group_alpha = '0;
  logic in_batch_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_screen_x, out_screen_y, out_screen_z, out_recip_w;
  logic [7:0] out_alpha;
  logic out_w_zero, out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  logic [63:0] matrix [NUM_REGS];
  screen_vtx_t pending_vtx [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  vertex_projective_transform #(.FRAC_BITS(FRAC)) dut (.*);

  function automatic logic signed [63:0] floor_div(input logic signed [95:0] v);
    logic signed [95:0] s;
    s = v >>> FRAC;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 64'sd2147483647;
    if (v < -96'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] coeff(input int r, input int c);
    logic [63:0] rg;
    rg = matrix[r * 2 + c / 2];
    return (c % 2) ? 64'(signed'(rg[63:32])) : 64'(signed'(rg[31:0]));
  endfunction

  function automatic logic signed [63:0] column_dot(input logic signed [63:0] p [3], input int c);
    logic signed [95:0] acc;
    acc = 0;
    for (int r = 0; r < 3; r++) acc += 96'(coeff(r, c)) * 96'(p[r]);
    return clamp32(96'(floor_div(acc)) + 96'(coeff(3, c)));
  endfunction

  function automatic screen_vtx_t project_vertex(input logic signed [31:0] x, y, z,
                                                 input logic [7:0] va, ga, input logic last);
    screen_vtx_t v;
    logic signed [63:0] p [3];
    logic signed [63:0] t [4];
    logic signed [63:0] r, w, q;
    p[0] = x; p[1] = y; p[2] = z;
    for (int c = 0; c < 4; c++) t[c] = column_dot(p, c);
    w = t[3];
    v.wz = (w == 0);
    if (w == 0) begin
      r = 64'sd2147483647;
    end else begin
      q = (64'sd1 <<< (2 * FRAC)) / (w < 0 ? -w : w);
      if (w < 0) r = (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
      else r = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
    end
    v.sx = 32'(clamp32(96'(floor_div(96'(t[0]) * 96'(r)))));
    v.sy = 32'(clamp32(96'(floor_div(96'(t[1]) * 96'(r)))));
    v.sz = 32'(clamp32(96'(floor_div(96'(t[2]) * 96'(r)))));
    v.rhw = r[31:0];
    v.alpha = (ga < ALPHA_KEEP) ? ga : va;
    v.last = last;
    return v;
  endfunction

  task automatic write_matrix_reg(input int idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 6'(idx * 8); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < NUM_REGS) matrix[idx] = val;
  endtask

  task automatic send_vertex(input logic signed [31:0] x, y, z,
                             input logic [7:0] va, ga, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pending_vtx.insert(pending_vtx.size(), project_vertex(x, y, z, va, ga, last));
    in_valid <= 1'b1;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    in_vertex_alpha <= va; in_group_alpha <= ga; in_batch_last <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_and_drain();
    in_valid <= 1'b0;
    wait (pending_vtx.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2 * 65536 * 200)) - 65536 * 200;
      2: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
      default: return $signed($urandom_range(64)) - 32;
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    logic [31:0] h [2];
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(3))
        0: h[i] = $urandom;
        1: h[i] = 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
        2: h[i] = '0;
        default: h[i] = 32'd65536;
      endcase
    end
    return {h[1], h[0]};
  endfunction

  task automatic test_identity_edges();
    logic signed [31:0] vals [5];
    vals = '{32'sh7fffffff, 32'sh80000000, 0, 32'sd65536, -32'sd65536};
    foreach (vals[i])
      send_vertex(vals[i], vals[(i + 1) % 5], vals[(i + 2) % 5], 8'hff, 8'hff, 1'b0);
    send_vertex(1, -1, 65536, 8'h00, 8'hff, 1'b1);
    send_vertex(3, 4, 5, 8'h5a, 8'h00, 1'b0);
    send_vertex(3, 4, 5, 8'h5a, 8'hfe, 1'b1);
    idle_and_drain();
  endtask

  // Translation w column zeroed and z feeds w, so a zero z gives w of zero.
  task automatic test_w_special();
    write_matrix_reg(5, {32'd65536, 32'd65536});
    write_matrix_reg(7, 64'd0);
    send_vertex(65536, 65536, 0, 8'h11, 8'hff, 1'b0);
    send_vertex(65536, 65536, 1, 8'h22, 8'hff, 1'b0);
    send_vertex(-65536, 65536, -1, 8'h33, 8'hff, 1'b1);
    send_vertex(65536, 65536, 32'sh7fffffff, 8'h44, 8'hff, 1'b0);
    send_vertex(65536, 65536, 32'sh80000000, 8'h55, 8'hff, 1'b0);
    send_vertex(65536, 65536, -32'sd65536, 8'h66, 8'hff, 1'b0);
    idle_and_drain();
    for (int i = 0; i < NUM_REGS; i++) write_matrix_reg(i, {64{1'b1}} >> (i % 2));
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 8'h01, 8'h02, 1'b1);
    idle_and_drain();
  endtask

  task automatic test_random_phase(input int sidle, input int rstall, input int count);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < NUM_REGS; i++) write_matrix_reg(i, rand_pair());
    for (int n = 0; n < count; n++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), 8'($urandom),
                  ($urandom_range(3) == 0) ? 8'hff : 8'($urandom), 1'($urandom));
    idle_and_drain();
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    screen_vtx_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vtx.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $time);
      end else begin
        e = pending_vtx.pop_front();
        if (out_screen_x !== e.sx || out_screen_y !== e.sy || out_screen_z !== e.sz ||
            out_recip_w !== e.rhw || out_alpha !== e.alpha || out_w_zero !== e.wz ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp %0d %0d %0d %0d a=%0d wz=%0b l=%0b",
                     e.sx, e.sy, e.sz, e.rhw, e.alpha, e.wz, e.last);
            $display("          got %0d %0d %0d %0d a=%0d wz=%0b l=%0b",
                     out_screen_x, out_screen_y, out_screen_z, out_recip_w, out_alpha,
                     out_w_zero, out_last);
          end
        end
      end
    end
  end

  initial begin
    matrix[0] = 64'd65536;      matrix[1] = 0;
    matrix[2] = 64'd65536 << 32; matrix[3] = 0;
    matrix[4] = 0;              matrix[5] = 64'd65536;
    matrix[6] = 0;              matrix[7] = 64'd65536 << 32;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_identity_edges();
    test_w_special();
    test_random_phase(0, 0, 150);
    test_random_phase(86, 0, 150);
    test_random_phase(0, 86, 150);
    test_random_phase(29, 29, 150);
    if (mismatches == 0) $display("tb_vertex_projective_transform: clean");
    else $display("tb_vertex_projective_transform: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_vertex_projective_transform: errors");
    $finish;
  end

endmodule

>>> files.f
rtl/vpt_pkg.sv
rtl/vpt_dot.sv
rtl/vpt_recip.sv
rtl/vpt_scale.sv
rtl/vertex_projective_transform.sv
rtl/vpt_checker.sv
sim/tb_vertex_projective_transform.sv
